// ===== hdl/uvs_pkg.sv =====
`timescale 1ns / 1ps

package uvs_pkg;

	localparam int BandBitsDefault  = 8;
	localparam int AngleBitsDefault = 16;
	localparam int TexFrac          = 15;
	localparam int CordicSteps      = 24;
	localparam int TrigW            = 32;
	localparam int BandsReset       = 16;
	localparam logic signed [TrigW-1:0] CordicK = 32'sd652032874;
	localparam int Q14One           = 16384;

	typedef enum logic [0:0] {
		REG_LATITUDE_BANDS  = 1'b0,
		REG_LONGITUDE_BANDS = 1'b1
	} cfg_reg_t;

	// Fields that ride alongside the angle datapath.
	typedef struct packed {
		logic [15:0] tex_u;
		logic [15:0] tex_v;
		logic        quad_valid;
		logic [15:0] upper;
		logic [15:0] lower;
		logic [15:0] lonb1;
	} side_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [15:0]        tex_u;
		logic [15:0]        tex_v;
		logic               quad_valid;
		logic [15:0]        upper;
		logic [15:0]        lower;
	} out_t;

	// Arctangent of 2^-step, in units of 2^-32 turn.
	function automatic logic [TrigW-1:0] atan_turn(input int step);
		logic [TrigW-1:0] v;
		unique case (step)
			0:       v = 32'd536870912;
			1:       v = 32'd316933406;
			2:       v = 32'd167458907;
			3:       v = 32'd85004756;
			4:       v = 32'd42667331;
			5:       v = 32'd21354465;
			6:       v = 32'd10679838;
			7:       v = 32'd5340245;
			8:       v = 32'd2670163;
			9:       v = 32'd1335087;
			10:      v = 32'd667544;
			11:      v = 32'd333772;
			12:      v = 32'd166886;
			13:      v = 32'd83443;
			14:      v = 32'd41722;
			15:      v = 32'd20861;
			16:      v = 32'd10430;
			17:      v = 32'd5215;
			18:      v = 32'd2608;
			19:      v = 32'd1304;
			20:      v = 32'd652;
			21:      v = 32'd326;
			22:      v = 32'd163;
			23:      v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] sat_q14(input logic signed [47:0] v);
		logic signed [15:0] r;
		if (v > 48'sd16384)
			r = 16'sd16384;
		else if (v < -48'sd16384)
			r = -16'sd16384;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage

// ===== hdl/uvs_div_cell.sv =====
`timescale 1ns / 1ps

module uvs_div_cell #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 9,
	parameter int QUO_W = 17,
	parameter int STEP  = 0
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] r_in,
	input  logic [DEN_W-1:0] d_in,
	input  logic [QUO_W-1:0] q_in,
	output logic [NUM_W-1:0] r_q,
	output logic [DEN_W-1:0] d_q,
	output logic [QUO_W-1:0] q_q
);

	logic [NUM_W-1:0] dsh;
	logic [NUM_W:0]   diff;
	logic             ge;

	assign dsh  = NUM_W'(d_in) << STEP;
	assign diff = {1'b0, r_in} - {1'b0, dsh};
	assign ge   = !diff[NUM_W];

	always_ff @(posedge clk) begin
		if (en) begin
			r_q <= ge ? diff[NUM_W-1:0] : r_in;
			d_q <= d_in;
			q_q <= {q_in[QUO_W-2:0], ge};
		end
	end

endmodule

// ===== hdl/uvs_cordic_cell.sv =====
`timescale 1ns / 1ps

module uvs_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [uvs_pkg::TrigW-1:0]     x_in,
	input  logic signed [uvs_pkg::TrigW-1:0]     y_in,
	input  logic signed [uvs_pkg::TrigW-1:0]     z_in,
	input  logic [1:0]                           quad_in,
	output logic signed [uvs_pkg::TrigW-1:0]     x_q,
	output logic signed [uvs_pkg::TrigW-1:0]     y_q,
	output logic signed [uvs_pkg::TrigW-1:0]     z_q,
	output logic [1:0]                           quad_q
);

	logic signed [uvs_pkg::TrigW-1:0] dx;
	logic signed [uvs_pkg::TrigW-1:0] dy;
	logic signed [uvs_pkg::TrigW-1:0] at;

	assign dx = y_in >>> STEP;
	assign dy = x_in >>> STEP;
	assign at = signed'(uvs_pkg::atan_turn(STEP));

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[uvs_pkg::TrigW-1]) begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				z_q <= z_in - at;
			end else begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				z_q <= z_in + at;
			end
			quad_q <= quad_in;
		end
	end

endmodule

// ===== hdl/uvs_out_buf.sv =====
`timescale 1ns / 1ps

module uvs_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  uvs_pkg::out_t push_data,
	input  logic          out_stall,
	output logic          out_valid,
	output uvs_pkg::out_t out_data,
	output logic          room
);

	uvs_pkg::out_t mem_q [2];
	logic [1:0]    count_q;
	logic          wr_q;
	logic          rd_q;
	logic          pop;

	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && !out_stall;
	assign room      = (count_q != 2'd2);
	assign out_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			count_q <= count_q + 2'(push) - 2'(pop);
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push)
		else $error("transaction pushed into a full output buffer");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("output buffer count out of range");

	a_stalled_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled output transaction changed");

endmodule

// ===== hdl/uv_sphere_vertex_generator_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// input     in         in_valid / in_stall      lat_index, long_index
// output    out        out_valid / out_stall    pos_x/y/z, tex_u/v, quad_valid, upper/lower_vertex
// config    in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One transaction is taken per cycle while the output buffer has room; the pipeline has
// max(ANGLE_BITS,15)+1 (at least 16) divider cells plus 24 CORDIC cells plus five more stages.
// The divider chain and the CORDIC chain make up most of these stages; each cell does one step.
// Reset clears the control state and sets both band counts to 16; no clearing pass.
// A two-entry output buffer absorbs a stall; the pipeline freezes only once it is full.

module uv_sphere_vertex_generator_top #(
	parameter int BAND_BITS  = uvs_pkg::BandBitsDefault,
	parameter int ANGLE_BITS = uvs_pkg::AngleBitsDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            lat_index,
	input  logic [7:0]            long_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [15:0]    pos_x,
	output logic signed [15:0]    pos_y,
	output logic signed [15:0]    pos_z,
	output logic [15:0]           tex_u,
	output logic [15:0]           tex_v,
	output logic                  quad_valid,
	output logic [15:0]           upper_vertex,
	output logic [15:0]           lower_vertex,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [0:0]            cfg_index,
	input  logic [BAND_BITS-1:0]  cfg_data
);

	localparam int B     = BAND_BITS;
	localparam int DS    = ((ANGLE_BITS > uvs_pkg::TexFrac) ? ANGLE_BITS : uvs_pkg::TexFrac) + 1;
	localparam int NW    = B + DS + 1;
	localparam int DW    = B + 1;
	localparam int NS    = uvs_pkg::CordicSteps;
	localparam int TW    = uvs_pkg::TrigW;
	localparam int RED   = DS + 2;
	localparam int LAST  = DS + 29;
	localparam int LANES = 4;

	logic [B-1:0] lat_rows_q;
	logic [B-1:0] long_bands_q;

	logic en;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_rows_q   <= B'(uvs_pkg::BandsReset);
			long_bands_q <= B'(uvs_pkg::BandsReset);
		end else if (cfg_valid && cfg_ready) begin
			unique case (uvs_pkg::cfg_reg_t'(cfg_index))
				uvs_pkg::REG_LATITUDE_BANDS:  lat_rows_q   <= cfg_data;
				uvs_pkg::REG_LONGITUDE_BANDS: long_bands_q <= cfg_data;
			endcase
		end
	end

	// Input stage: zero band count reads as one, indices clamp to the band count.
	logic [B-1:0] latb_c, lonb_c, lat_c, lon_c, lat_ext, lon_ext;
	logic [B-1:0] lat_s1, lon_s1, latb_s1, lonb_s1;
	logic         valid_s [1:LAST];

	assign latb_c  = (lat_rows_q == '0) ? B'(1) : lat_rows_q;
	assign lonb_c  = (long_bands_q == '0) ? B'(1) : long_bands_q;
	assign lat_ext = B'(lat_index);
	assign lon_ext = B'(long_index);
	assign lat_c   = (lat_ext > latb_c) ? latb_c : lat_ext;
	assign lon_c   = (lon_ext > lonb_c) ? lonb_c : lon_ext;

	always_ff @(posedge clk) begin
		if (en) begin
			lat_s1  <= lat_c;
			lon_s1  <= lon_c;
			latb_s1 <= latb_c;
			lonb_s1 <= lonb_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++)
				valid_s[k] <= 1'b0;
		end else if (en) begin
			valid_s[1] <= in_valid;
			for (int k = 2; k <= LAST; k++)
				valid_s[k] <= valid_s[k-1];
		end
	end

	// Divider lanes: theta, phi, tex_u, tex_v. Each computes
	// floor((num * 2^(shift+1) + den) / (2 * den)), which rounds half up.
	logic [NW-1:0] div_r [LANES][DS+1];
	logic [DW-1:0] div_d [LANES][DS+1];
	logic [DS-1:0] div_q [LANES][DS+1];

	assign div_r[0][0] = (NW'(lat_s1) << ANGLE_BITS) + NW'(latb_s1);
	assign div_r[1][0] = (NW'(lon_s1) << (ANGLE_BITS + 1)) + NW'(lonb_s1);
	assign div_r[2][0] = (NW'(lonb_s1 - lon_s1) << (uvs_pkg::TexFrac + 1)) + NW'(lonb_s1);
	assign div_r[3][0] = (NW'(latb_s1 - lat_s1) << (uvs_pkg::TexFrac + 1)) + NW'(latb_s1);
	assign div_d[0][0] = {latb_s1, 1'b0};
	assign div_d[1][0] = {lonb_s1, 1'b0};
	assign div_d[2][0] = {lonb_s1, 1'b0};
	assign div_d[3][0] = {latb_s1, 1'b0};

	for (genvar l = 0; l < LANES; l++) begin : g_div_lane
		assign div_q[l][0] = '0;
		for (genvar k = 0; k < DS; k++) begin : g_div_cell
			uvs_div_cell #(
				.NUM_W (NW),
				.DEN_W (DW),
				.QUO_W (DS),
				.STEP  (DS - 1 - k)
			) u_cell (
				.clk  (clk),
				.en   (en),
				.r_in (div_r[l][k]),
				.d_in (div_d[l][k]),
				.q_in (div_q[l][k]),
				.r_q  (div_r[l][k+1]),
				.d_q  (div_d[l][k+1]),
				.q_q  (div_q[l][k+1])
			);
		end
	end

	// Quad corner indices and the rest of the side fields.
	uvs_pkg::side_t side_in;
	uvs_pkg::side_t side_s [2:LAST];
	uvs_pkg::side_t side3_c;
	uvs_pkg::side_t side_red_c;
	logic [2*B:0]   upper_full;
	logic [B:0]     lonb1;
	logic           qv;

	assign lonb1      = (B+1)'(lonb_s1) + (B+1)'(1);
	assign qv         = (lat_s1 < latb_s1) && (lon_s1 < lonb_s1);
	assign upper_full = (2*B+1)'(lat_s1) * (2*B+1)'(lonb1) + (2*B+1)'(lon_s1);

	always_comb begin
		side_in            = '0;
		side_in.quad_valid = qv;
		side_in.upper      = qv ? 16'(upper_full) : 16'd0;
		side_in.lonb1      = 16'(lonb1);
	end

	always_comb begin
		side3_c       = side_s[2];
		side3_c.lower = side_s[2].quad_valid ? side_s[2].upper + side_s[2].lonb1 : 16'd0;
	end

	// The texture quotients leave the divider chains at this stage.
	always_comb begin
		side_red_c       = side_s[RED-1];
		side_red_c.tex_u = div_q[2][DS][15:0];
		side_red_c.tex_v = div_q[3][DS][15:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[2] <= side_in;
			side_s[3] <= side3_c;
			for (int k = 4; k <= LAST; k++)
				side_s[k] <= (k == RED) ? side_red_c : side_s[k-1];
		end
	end

	// Angle reduction to the nearest quarter turn plus a remainder.
	logic [ANGLE_BITS-1:0] ang [2];
	logic [TW-1:0]         ang32 [2];
	logic [TW-1:0]         ang_bias [2];
	logic [1:0]            quad_c [2];
	logic signed [TW-1:0]  rz_s [2];
	logic [1:0]            rq_s [2];

	assign ang[0] = div_q[0][DS][ANGLE_BITS-1:0];
	assign ang[1] = div_q[1][DS][ANGLE_BITS-1:0];

	for (genvar l = 0; l < 2; l++) begin : g_reduce
		assign ang32[l]    = TW'(ang[l]) << (TW - ANGLE_BITS);
		assign ang_bias[l] = ang32[l] + 32'h2000_0000;
		assign quad_c[l]   = ang_bias[l][TW-1:TW-2];

		always_ff @(posedge clk) begin
			if (en) begin
				rz_s[l] <= signed'(ang32[l] - {quad_c[l], 30'd0});
				rq_s[l] <= quad_c[l];
			end
		end
	end

	// CORDIC chains, lane 0 for theta and lane 1 for phi.
	logic signed [TW-1:0] cx [2][NS+1];
	logic signed [TW-1:0] cy [2][NS+1];
	logic signed [TW-1:0] cz [2][NS+1];
	logic [1:0]           cq [2][NS+1];

	for (genvar l = 0; l < 2; l++) begin : g_cordic_lane
		assign cx[l][0] = uvs_pkg::CordicK;
		assign cy[l][0] = '0;
		assign cz[l][0] = rz_s[l];
		assign cq[l][0] = rq_s[l];
		for (genvar i = 0; i < NS; i++) begin : g_cordic_cell
			uvs_cordic_cell #(.STEP(i)) u_cell (
				.clk     (clk),
				.en      (en),
				.x_in    (cx[l][i]),
				.y_in    (cy[l][i]),
				.z_in    (cz[l][i]),
				.quad_in (cq[l][i]),
				.x_q     (cx[l][i+1]),
				.y_q     (cy[l][i+1]),
				.z_q     (cz[l][i+1]),
				.quad_q  (cq[l][i+1])
			);
		end
	end

	// Quarter-turn correction.
	logic signed [TW-1:0] cos_s [2];
	logic signed [TW-1:0] sin_s [2];

	for (genvar l = 0; l < 2; l++) begin : g_quadrant
		always_ff @(posedge clk) begin
			if (en) begin
				unique case (cq[l][NS])
					2'd0: begin
						cos_s[l] <= cx[l][NS];
						sin_s[l] <= cy[l][NS];
					end
					2'd1: begin
						cos_s[l] <= -cy[l][NS];
						sin_s[l] <= cx[l][NS];
					end
					2'd2: begin
						cos_s[l] <= -cx[l][NS];
						sin_s[l] <= -cy[l][NS];
					end
					default: begin
						cos_s[l] <= cy[l][NS];
						sin_s[l] <= -cx[l][NS];
					end
				endcase
			end
		end
	end

	// Products, then rounding and saturation.
	logic signed [63:0] prod_x_s, prod_z_s;
	logic signed [15:0] pos_y_s;
	logic signed [15:0] pos_x_s, pos_z_s, pos_y_out_s;
	logic signed [TW:0] ct_round;
	logic signed [63:0] px_round, pz_round;

	assign ct_round = {cos_s[0][TW-1], cos_s[0]} + 33'sd32768;
	assign px_round = prod_x_s + (64'sd1 <<< 45);
	assign pz_round = prod_z_s + (64'sd1 <<< 45);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s    <= cos_s[1] * sin_s[0];
			prod_z_s    <= sin_s[1] * sin_s[0];
			pos_y_s     <= uvs_pkg::sat_q14(48'(ct_round >>> 16));
			pos_x_s     <= uvs_pkg::sat_q14(48'(px_round >>> 46));
			pos_z_s     <= uvs_pkg::sat_q14(48'(pz_round >>> 46));
			pos_y_out_s <= pos_y_s;
		end
	end

	// Output buffer.
	uvs_pkg::out_t push_data;
	uvs_pkg::out_t out_data;
	logic          push;

	always_comb begin
		push_data.pos_x      = pos_x_s;
		push_data.pos_y      = pos_y_out_s;
		push_data.pos_z      = pos_z_s;
		push_data.tex_u      = side_s[LAST].tex_u;
		push_data.tex_v      = side_s[LAST].tex_v;
		push_data.quad_valid = side_s[LAST].quad_valid;
		push_data.upper      = side_s[LAST].upper;
		push_data.lower      = side_s[LAST].lower;
	end

	assign push     = en && valid_s[LAST];
	assign in_stall = !en;

	uvs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.room      (en)
	);

	assign pos_x        = out_data.pos_x;
	assign pos_y        = out_data.pos_y;
	assign pos_z        = out_data.pos_z;
	assign tex_u        = out_data.tex_u;
	assign tex_v        = out_data.tex_v;
	assign quad_valid   = out_data.quad_valid;
	assign upper_vertex = out_data.upper;
	assign lower_vertex = out_data.lower;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s[1])
		else $error("accepted transaction did not enter the pipeline");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_valid)
		else $error("finished transaction not presented at the output");

	a_stalled_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled output transaction was dropped");

endmodule

// ===== verif/tb_uv_sphere_vertex_generator_top.sv =====
`timescale 1ns / 1ps

module tb_uv_sphere_vertex_generator_top;

	localparam int NumRandom = 1450;
	localparam int Latency = 46;
	localparam int IdleLimit = 4000;

	typedef struct {
		logic signed [15:0] x, y, z;
		logic [15:0] u, v;
		logic qv;
		logic [15:0] upper, lower;
	} vertex_t;

	// Expected vertices, computed from the grid point and the band counts at
	// the time the input transaction was accepted.
	class vertex_scoreboard;
		vertex_t pending[$];
		int errors;
		logic [7:0] lat_rows, lon_bands;

		function new();
			errors = 0;
			lat_rows = 8'(uvs_pkg::BandsReset);
			lon_bands = 8'(uvs_pkg::BandsReset);
		endfunction

		function longint floor_div2(longint v, int s);
			return v >>> s;
		endfunction

		function longint ratio_hu(longint num, int sh, longint den);
			return ((num << (sh + 1)) + den) / (den << 1);
		endfunction

		function longint sat14(longint v);
			if (v > uvs_pkg::Q14One) return uvs_pkg::Q14One;
			if (v < -uvs_pkg::Q14One) return -uvs_pkg::Q14One;
			return v;
		endfunction

		function void trig(logic [31:0] ang, output longint c, output longint s);
			logic [1:0] q;
			logic [31:0] rem;
			longint z, xx, yy, dx, dy;
			q = 2'((ang + 32'h2000_0000) >> 30);
			rem = ang - ({30'd0, q} << 30);
			z = longint'($signed(rem));
			xx = uvs_pkg::CordicK;
			yy = 0;
			for (int i = 0; i < uvs_pkg::CordicSteps; i++) begin
				dx = floor_div2(yy, i);
				dy = floor_div2(xx, i);
				if (z >= 0) begin
					xx -= dx; yy += dy; z -= longint'(uvs_pkg::atan_turn(i));
				end else begin
					xx += dx; yy -= dy; z += longint'(uvs_pkg::atan_turn(i));
				end
			end
			case (q)
				2'd0: begin c = xx; s = yy; end
				2'd1: begin c = -yy; s = xx; end
				2'd2: begin c = -xx; s = -yy; end
				default: begin c = yy; s = -xx; end
			endcase
		endfunction

		function void note_grid_point(logic [7:0] lat_in, logic [7:0] lon_in);
			vertex_t e;
			longint latb, lonb, lat, lon, th, ph, ct, st, cp, sp;
			latb = (lat_rows == 0) ? 1 : lat_rows;
			lonb = (lon_bands == 0) ? 1 : lon_bands;
			lat = (lat_in > latb) ? latb : lat_in;
			lon = (lon_in > lonb) ? lonb : lon_in;
			th = ratio_hu(lat, 15, latb) & 16'hFFFF;
			ph = ratio_hu(lon, 16, lonb) & 16'hFFFF;
			trig(32'(th << 16), ct, st);
			trig(32'(ph << 16), cp, sp);
			e.qv = (lat < latb) && (lon < lonb);
			e.upper = e.qv ? 16'(lat * (lonb + 1) + lon) : 16'd0;
			e.lower = e.qv ? 16'(e.upper + lonb + 1) : 16'd0;
			e.x = 16'(sat14(floor_div2(cp * st + (64'sd1 <<< 45), 46)));
			e.y = 16'(sat14(floor_div2(ct + (64'sd1 <<< 15), 16)));
			e.z = 16'(sat14(floor_div2(sp * st + (64'sd1 <<< 45), 46)));
			e.u = 16'(ratio_hu(lonb - lon, 15, lonb));
			e.v = 16'(ratio_hu(latb - lat, 15, latb));
			pending = {pending, e};
		endfunction

		function void check_vertex(vertex_t got);
			vertex_t e;
			if (pending.size() == 0) begin
				$error("unexpected vertex transaction");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.x !== e.x) begin $error("pos_x exp %0d got %0d", e.x, got.x); errors++; end
			if (got.y !== e.y) begin $error("pos_y exp %0d got %0d", e.y, got.y); errors++; end
			if (got.z !== e.z) begin $error("pos_z exp %0d got %0d", e.z, got.z); errors++; end
			if (got.u !== e.u) begin $error("tex_u exp %0d got %0d", e.u, got.u); errors++; end
			if (got.v !== e.v) begin $error("tex_v exp %0d got %0d", e.v, got.v); errors++; end
			if (got.qv !== e.qv) begin
				$error("quad_valid exp %0d got %0d", e.qv, got.qv); errors++;
			end
			if (got.upper !== e.upper) begin
				$error("upper_vertex exp %0d got %0d", e.upper, got.upper); errors++;
			end
			if (got.lower !== e.lower) begin
				$error("lower_vertex exp %0d got %0d", e.lower, got.lower); errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0, quad_valid;
	logic [7:0] lat_index = 0, long_index = 0;
	logic signed [15:0] pos_x, pos_y, pos_z;
	logic [15:0] tex_u, tex_v, upper_vertex, lower_vertex;
	logic cfg_valid = 0, cfg_ready;
	logic [0:0] cfg_index = uvs_pkg::REG_LATITUDE_BANDS;
	logic [7:0] cfg_data = 0;

	vertex_scoreboard grid_sb = new();
	bit hold_off = 0;
	int idle_cycles = 0;

	uv_sphere_vertex_generator_top dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Valid stays high into the next call when no idle cycles are drawn.
	task automatic send_grid_point(logic [7:0] lat, logic [7:0] lon);
		int gap;
		lat_index <= lat;
		long_index <= lon;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		grid_sb.note_grid_point(lat, lon);
		@(negedge clk);
		gap = $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic write_bands(uvs_pkg::cfg_reg_t idx, logic [7:0] val);
		in_valid <= 0;
		while (grid_sb.pending.size() != 0) @(negedge clk);
		repeat (Latency) @(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == uvs_pkg::REG_LATITUDE_BANDS) grid_sb.lat_rows = val;
		else grid_sb.lon_bands = val;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// Random draw that favors indices within the grid but also crosses it.
	function automatic logic [7:0] pick_index(logic [7:0] bands);
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return 8'($urandom_range(0, bands));
		if (r < 8) return bands;
		return 8'($urandom);
	endfunction

	// Receiver: random stall per transaction, one long hold-off on request.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1;
				repeat (300) @(negedge clk);
				hold_off = 0;
				out_stall <= 0;
			end else begin
				n = $urandom_range(0, 8);
				if (n != 0) begin
					out_stall <= 1;
					repeat (n) @(negedge clk);
				end
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		vertex_t got;
		if (out_valid && !out_stall) begin
			got.x = pos_x; got.y = pos_y; got.z = pos_z;
			got.u = tex_u; got.v = tex_v; got.qv = quad_valid;
			got.upper = upper_vertex; got.lower = lower_vertex;
			grid_sb.check_vertex(got);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [7:0] lb, ob;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Default 16x16 grid: poles, seam, corners and indices past the grid.
		send_grid_point(0, 0);
		send_grid_point(16, 16);
		send_grid_point(8, 4);
		send_grid_point(4, 12);
		send_grid_point(15, 15);
		send_grid_point(255, 255);
		send_grid_point(8'hAA, 8'h55);
		send_grid_point(8'h55, 8'hAA);
		send_grid_point(0, 16);
		// Zero band counts act as one.
		write_bands(uvs_pkg::REG_LATITUDE_BANDS, 0);
		write_bands(uvs_pkg::REG_LONGITUDE_BANDS, 0);
		send_grid_point(0, 0);
		send_grid_point(1, 1);
		send_grid_point(200, 0);
		// Largest grid, where the vertex indices still fit in 16 bits.
		write_bands(uvs_pkg::REG_LATITUDE_BANDS, 255);
		write_bands(uvs_pkg::REG_LONGITUDE_BANDS, 255);
		send_grid_point(254, 254);
		send_grid_point(255, 255);
		send_grid_point(128, 64);
		send_grid_point(1, 1);
		send_grid_point(200, 100);
		write_bands(uvs_pkg::REG_LATITUDE_BANDS, 1);
		write_bands(uvs_pkg::REG_LONGITUDE_BANDS, 3);
		send_grid_point(0, 0);
		send_grid_point(1, 3);
		send_grid_point(0, 2);
		for (int ph = 0; ph < 6; ph++) begin
			lb = (ph == 0) ? 8'd255 : (ph == 1) ? 8'd1 : 8'($urandom_range(1, 255));
			ob = (ph == 0) ? 8'd1 : (ph == 1) ? 8'd255 : 8'($urandom_range(1, 255));
			if (ph == 5) begin
				lb = 0;
				ob = 8'($urandom_range(0, 40));
			end
			write_bands(uvs_pkg::REG_LATITUDE_BANDS, lb);
			write_bands(uvs_pkg::REG_LONGITUDE_BANDS, ob);
			if (ph == 2) hold_off = 1;
			for (int i = 0; i < NumRandom / 6; i++)
				send_grid_point(pick_index(lb), pick_index(ob));
		end
		in_valid <= 0;
		while (grid_sb.pending.size() != 0) @(negedge clk);
		repeat (Latency) @(negedge clk);
		if (grid_sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
